[src/atlc_pkg.sv]
// shared types and constants of the adaptive traffic light controller
package atlc_pkg;

  // fixed geometry of the junction
  localparam int ROAD_COUNT = 4;
  localparam int ROAD_BITS  = 2;
  localparam int COUNT_BITS = 8;
  localparam int TICK_BITS  = 8;

  // light codes
  localparam logic [1:0] LIGHT_RED    = 2'd0;
  localparam logic [1:0] LIGHT_YELLOW = 2'd1;
  localparam logic [1:0] LIGHT_GREEN  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_GREEN  = 2'd0;
  localparam logic [1:0] REG_YELLOW = 2'd1;
  localparam logic [1:0] REG_GAP    = 2'd2;

  // configuration reset values
  localparam logic [TICK_BITS-1:0] GREEN_RST  = 8'd5;
  localparam logic [TICK_BITS-1:0] YELLOW_RST = 8'd2;
  localparam logic [TICK_BITS-1:0] GAP_RST    = 8'd1;
  localparam logic [TICK_BITS-1:0] TICK_MAX   = 8'd255;

  typedef enum logic [1:0] {
    PH_SELECT = 2'd0,
    PH_GREEN  = 2'd1,
    PH_YELLOW = 2'd2,
    PH_GAP    = 2'd3
  } phase_t;

  typedef logic [ROAD_COUNT-1:0][COUNT_BITS-1:0] counts_t;
  typedef logic [ROAD_COUNT-1:0][1:0]            lights_t;

  // history of the last road picked by demand
  typedef struct packed {
    logic                 valid;
    logic [ROAD_BITS-1:0] road;
  } hist_t;

  // one result beat
  typedef struct packed {
    lights_t              light;
    logic [ROAD_BITS-1:0] served_road;
    logic                 emergency_service;
  } res_t;

endpackage

[src/atlc_select.sv]
// demand-based road choice: busiest road, no repeat of the last road picked by demand
module atlc_select
  import atlc_pkg::*;
(
  input  counts_t              counts,
  input  hist_t                hist,
  output logic [ROAD_BITS-1:0] road
);

  logic [ROAD_BITS-1:0]  best;
  logic [COUNT_BITS-1:0] best_count;

  // arg-max, ties kept on the lowest index
  always_comb begin
    best       = '0;
    best_count = counts[0];
    for (int i = 1; i < ROAD_COUNT; i++) begin
      if (counts[i] > best_count) begin
        best_count = counts[i];
        best       = ROAD_BITS'(i);
      end
    end
  end

  // step on to the next road when the winner was the last road picked by demand
  always_comb begin
    if (hist.valid && (best == hist.road)) begin
      if (hist.road == ROAD_BITS'(ROAD_COUNT - 1)) begin
        road = '0;
      end else begin
        road = hist.road + ROAD_BITS'(1);
      end
    end else begin
      road = best;
    end
  end

endmodule

[src/adaptive_traffic_light_controller.sv]
// top level of the adaptive traffic light controller
//
// Each input beat is one time tick: four road queue counts and an optional
// emergency request. Each accepted beat yields exactly one result beat with
// the four lights, the served road and the emergency-service flag after that
// tick. Emergency requests are latched and served at the next selection.
// Input beats are taken while in_valid is high and in_stall is low; results
// leave while out_valid is high and out_stall is low.
// A beat's result is registered in the result register, or in the skid entry
// while a result waits. Throughput is one beat per cycle while in_stall is low;
// the tick update is one pass of compare and timer logic between state registers.
// A result register backed by one skid entry parts the two sides, so a beat
// is still taken while a result waits. in_stall rises only when both entries
// are full, and falls the cycle after the receiver takes a result.
// Reset (rst_n low, synchronous) sets green 5, yellow 2, gap 1 ticks, road 0
// green with the others red, a selection due on the first tick, no pending
// emergency and both result entries empty.
// cfg_we writes cfg_data into register cfg_index (0 green, 1 yellow, 2 gap).
module adaptive_traffic_light_controller
  import atlc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [TICK_BITS-1:0]  cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COUNT_BITS-1:0] in_count_ns,
  input  logic [COUNT_BITS-1:0] in_count_ew,
  input  logic [COUNT_BITS-1:0] in_count_sn,
  input  logic [COUNT_BITS-1:0] in_count_we,
  input  logic                  in_emergency_request,
  input  logic [ROAD_BITS-1:0]  in_emergency_road,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_light_ns,
  output logic [1:0]            out_light_ew,
  output logic [1:0]            out_light_sn,
  output logic [1:0]            out_light_we,
  output logic [ROAD_BITS-1:0]  out_served_road,
  output logic                  out_emergency_service
);

  // configuration
  logic [TICK_BITS-1:0] green_r, yellow_r, gap_r;

  // controller state
  phase_t               phase_r, phase_nxt;
  logic [TICK_BITS-1:0] timer_r, timer_nxt;
  logic [ROAD_BITS-1:0] active_road_r, active_road_nxt;
  hist_t                hist_r, hist_nxt;
  logic                 pend_valid_r, pend_valid_nxt;
  logic [ROAD_BITS-1:0] pend_road_r, pend_road_nxt;
  lights_t              light_r, light_nxt;
  logic                 serv_em_r, serv_em_nxt;

  // result buffer
  logic out_valid_r, skid_valid_r;
  res_t out_r, skid_r, res_nxt;

  logic                 in_take, out_take;
  logic                 green_done, in_yellow, yellow_done, in_gap, gap_done, do_select;
  logic [TICK_BITS-1:0] timer_y, timer_g, timer_base;
  logic                 pend_v;
  logic [ROAD_BITS-1:0] pend_road, demand_road, new_road;
  counts_t              counts;

  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid_r && !out_stall;
  assign in_stall = skid_valid_r;

  assign counts = {in_count_we, in_count_sn, in_count_ew, in_count_ns};

  atlc_select u_select (
    .counts (counts),
    .hist   (hist_r),
    .road   (demand_road)
  );

  // phase sequencing: green, yellow and gap may all expire on one tick
  always_comb begin
    green_done  = (phase_r == PH_GREEN) && (timer_r >= green_r);
    in_yellow   = (phase_r == PH_YELLOW) || green_done;
    timer_y     = green_done ? '0 : timer_r;
    yellow_done = in_yellow && (timer_y >= yellow_r);
    in_gap      = (phase_r == PH_GAP) || yellow_done;
    timer_g     = yellow_done ? '0 : timer_y;
    gap_done    = in_gap && (timer_g >= gap_r);
    do_select   = (phase_r == PH_SELECT) || gap_done;

    if (do_select) begin
      phase_nxt = PH_GREEN;
    end else if (in_gap) begin
      phase_nxt = PH_GAP;
    end else if (in_yellow) begin
      phase_nxt = PH_YELLOW;
    end else begin
      phase_nxt = PH_GREEN;
    end

    timer_base = do_select ? '0 : timer_g;
    timer_nxt  = (timer_base == TICK_MAX) ? timer_base : timer_base + TICK_BITS'(1);
  end

  // road choice, emergency latch and lights
  always_comb begin
    pend_v    = pend_valid_r || in_emergency_request;
    pend_road = in_emergency_request ? in_emergency_road : pend_road_r;
    new_road  = pend_v ? pend_road : demand_road;

    pend_valid_nxt  = pend_v;
    pend_road_nxt   = pend_road;
    active_road_nxt = active_road_r;
    hist_nxt        = hist_r;
    serv_em_nxt     = serv_em_r;
    light_nxt       = light_r;

    if (green_done) begin
      light_nxt[active_road_r] = LIGHT_YELLOW;
    end

    if (do_select) begin
      active_road_nxt = new_road;
      if (pend_v) begin
        pend_valid_nxt = 1'b0;
        serv_em_nxt    = 1'b1;
      end else begin
        hist_nxt.valid = 1'b1;
        hist_nxt.road  = new_road;
        serv_em_nxt    = 1'b0;
      end
      for (int i = 0; i < ROAD_COUNT; i++) begin
        light_nxt[i] = LIGHT_RED;
      end
      light_nxt[new_road] = LIGHT_GREEN;
    end

    res_nxt.light             = light_nxt;
    res_nxt.served_road       = active_road_nxt;
    res_nxt.emergency_service = serv_em_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      green_r  <= GREEN_RST;
      yellow_r <= YELLOW_RST;
      gap_r    <= GAP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GREEN:  green_r  <= cfg_data;
        REG_YELLOW: yellow_r <= cfg_data;
        REG_GAP:    gap_r    <= cfg_data;
        default:    ;
      endcase
    end
  end

  // state update once per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_SELECT;
      timer_r       <= '0;
      active_road_r <= '0;
      hist_r        <= '0;
      pend_valid_r  <= 1'b0;
      pend_road_r   <= '0;
      serv_em_r     <= 1'b0;
      for (int i = 0; i < ROAD_COUNT; i++) begin
        light_r[i] <= (i == 0) ? LIGHT_GREEN : LIGHT_RED;
      end
    end else if (in_take) begin
      phase_r       <= phase_nxt;
      timer_r       <= timer_nxt;
      active_road_r <= active_road_nxt;
      hist_r        <= hist_nxt;
      pend_valid_r  <= pend_valid_nxt;
      pend_road_r   <= pend_road_nxt;
      serv_em_r     <= serv_em_nxt;
      light_r       <= light_nxt;
    end
  end

  // result register with one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (in_take) begin
      if (!out_valid_r || out_take) begin
        out_r       <= res_nxt;
        out_valid_r <= 1'b1;
      end else begin
        skid_r       <= res_nxt;
        skid_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_light_ns          = out_r.light[0];
  assign out_light_ew          = out_r.light[1];
  assign out_light_sn          = out_r.light[2];
  assign out_light_we          = out_r.light[3];
  assign out_served_road       = out_r.served_road;
  assign out_emergency_service = out_r.emergency_service;

  // skid entry only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry full with result register empty");

  // the served road always shows a non-red light
  a_served_lit: assert property (@(posedge clk) disable iff (!rst_n)
    light_r[active_road_r] != LIGHT_RED)
    else $error("served road shows red");

  // green phase shows green on the served road
  a_green_shown: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_GREEN) |-> (light_r[active_road_r] == LIGHT_GREEN))
    else $error("green phase without green light");

  // yellow stays up through yellow and gap
  a_yellow_shown: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_YELLOW || phase_r == PH_GAP) |->
      (light_r[active_road_r] == LIGHT_YELLOW))
    else $error("yellow or gap phase without yellow light");

  // every tick counts at least once in the phase it ends in
  a_timer_running: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_SELECT) |-> (timer_r != '0))
    else $error("phase timer zero outside selection");

endmodule
